>>> hdl/bgr_pkg.sv
// Package for the button gesture recogniser: event codes, register indexes,
// configuration and result bundle types. No dependencies.
package bgr_pkg;

  // Event codes carried on the result channel.
  typedef enum logic [3:0] {
    EV_CLICKS   = 4'd0,
    EV_SELECT   = 4'd1,
    EV_ENTER    = 4'd2,
    EV_WARN     = 4'd3,
    EV_ARMED    = 4'd4,
    EV_CANCEL   = 4'd5,
    EV_RESET    = 4'd6,
    EV_ACTIVITY = 4'd7,
    EV_NEXT     = 4'd8
  } evt_code_e;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DEBOUNCE    = 3'd0;
  localparam logic [2:0] CFG_MEDIUM_HOLD = 3'd1;
  localparam logic [2:0] CFG_WARN_HOLD   = 3'd2;
  localparam logic [2:0] CFG_LONG_HOLD   = 3'd3;
  localparam logic [2:0] CFG_CONFIRM_WIN = 3'd4;
  localparam logic [2:0] CFG_SHORT_MAX   = 3'd5;
  localparam logic [2:0] CFG_CLICK_WIN   = 3'd6;
  localparam logic [2:0] CFG_ACTIVE_LOW  = 3'd7;

  // Limits and counts.
  localparam logic [10:0] CLICK_WIN_MIN  = 11'd50;
  localparam logic [10:0] CLICK_WIN_MAX  = 11'd2000;
  localparam logic [1:0]  CLICK_CAP      = 2'd3;
  localparam logic [1:0]  CONFIRM_NEEDED = 2'd2;

  // Register file as seen by the recogniser core.
  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] medium_hold_ms;
    logic [15:0] warning_hold_ms;
    logic [15:0] long_hold_ms;
    logic [15:0] confirm_window_ms;
    logic [15:0] click_limit_ms;
    logic [10:0] click_window_ms;
    logic        active_low;
  } cfg_t;

  // All result items caused by one tick.
  typedef struct packed {
    logic [2:0]       count;
    logic [3:0][3:0]  code;
    logic [3:0][1:0]  clicks;
  } evt_bundle_t;

endpackage

>>> hdl/bgr_core.sv
// Gesture recogniser core: debounce, hold timing, click gathering and the
// factory-reset confirmation. Depends on bgr_pkg.
module bgr_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 pin_level_i,
  input  logic                 menu_active_i,
  input  logic                 menu_enabled_i,
  input  bgr_pkg::cfg_t        cfg_i,
  output bgr_pkg::evt_bundle_t bundle_o
);
  import bgr_pkg::*;

  logic [31:0] tick_q, tick_d;
  logic        prior_q, prior_d;
  logic [31:0] change_q, change_d;
  logic        stable_q, stable_d;
  logic [31:0] pstart_q, pstart_d;
  logic        pvalid_q, pvalid_d;
  logic        mfired_q, mfired_d;
  logic        wfired_q, wfired_d;
  logic        lfired_q, lfired_d;
  logic        armed_q, armed_d;
  logic [31:0] deadline_q, deadline_d;
  logic [1:0]  confirm_q, confirm_d;
  logic [1:0]  pend_q, pend_d;
  logic [31:0] lct_q, lct_d;

  logic [31:0] since_arm, since_click, held;
  logic        reading;
  logic        settled;
  logic [1:0]  confirm_inc;
  logic [2:0]  n;

  // Next state and the events of the tick on the input ports.
  always_comb begin
    tick_d     = tick_q + 32'd1;
    prior_d    = prior_q;
    change_d   = change_q;
    stable_d   = stable_q;
    pstart_d   = pstart_q;
    pvalid_d   = pvalid_q;
    mfired_d   = mfired_q;
    wfired_d   = wfired_q;
    lfired_d   = lfired_q;
    armed_d    = armed_q;
    deadline_d = deadline_q;
    confirm_d  = confirm_q;
    pend_d     = pend_q;
    lct_d      = lct_q;
    n          = 3'd0;
    bundle_o   = '0;

    since_arm   = tick_d - deadline_q;
    since_click = tick_d - lct_q;
    held        = tick_d - pstart_q;
    confirm_inc = confirm_q + 2'd1;

    // Confirmation window has run out.
    if (armed_q && !since_arm[31]) begin
      armed_d   = 1'b0;
      confirm_d = 2'd0;
      bundle_o.code[n[1:0]] = EV_CANCEL;
      n = n + 3'd1;
    end

    // Gathered clicks are reported once the click window has passed.
    if (!armed_d && (pend_q != 2'd0) && (since_click > {21'd0, cfg_i.click_window_ms})) begin
      bundle_o.code[n[1:0]]   = EV_CLICKS;
      bundle_o.clicks[n[1:0]] = pend_q;
      n      = n + 3'd1;
      pend_d = 2'd0;
      lct_d  = 32'd0;
    end

    // Debounce: the level must stay unchanged for the debounce time.
    reading = pin_level_i ^ cfg_i.active_low;
    if (reading != prior_q) begin
      change_d = tick_d;
      prior_d  = reading;
    end
    settled = (tick_d - change_d) >= {16'd0, cfg_i.debounce_ms};

    if (settled) begin
      // Hold events while the button is down.
      if (reading && pvalid_q) begin
        if (!mfired_q && (held >= {16'd0, cfg_i.medium_hold_ms})
            && (held < {16'd0, cfg_i.long_hold_ms})) begin
          mfired_d = 1'b1;
          pend_d   = 2'd0;
          lct_d    = 32'd0;
          if (menu_active_i) begin
            bundle_o.code[n[1:0]] = EV_SELECT;
            n = n + 3'd1;
          end else if (menu_enabled_i) begin
            bundle_o.code[n[1:0]] = EV_ENTER;
            n = n + 3'd1;
          end
        end
        if (!wfired_q && (held >= {16'd0, cfg_i.warning_hold_ms})) begin
          wfired_d = 1'b1;
          bundle_o.code[n[1:0]] = EV_WARN;
          n = n + 3'd1;
        end
        if (!lfired_q && (held >= {16'd0, cfg_i.long_hold_ms})) begin
          lfired_d = 1'b1;
          pend_d   = 2'd0;
          lct_d    = 32'd0;
          bundle_o.code[n[1:0]] = EV_ARMED;
          n = n + 3'd1;
        end
      end

      // Edge of the debounced level.
      if (reading != stable_q) begin
        stable_d = reading;
        if (reading) begin
          pstart_d = tick_d;
          pvalid_d = 1'b1;
          mfired_d = 1'b0;
          wfired_d = 1'b0;
          lfired_d = 1'b0;
          bundle_o.code[n[1:0]] = EV_ACTIVITY;
          n = n + 3'd1;
        end else begin
          if (pvalid_q) begin
            if (lfired_d) begin
              // Release after a long hold arms the factory reset.
              armed_d    = 1'b1;
              deadline_d = tick_d + {16'd0, cfg_i.confirm_window_ms};
              confirm_d  = 2'd0;
            end else if (armed_d) begin
              if (confirm_inc >= CONFIRM_NEEDED) begin
                armed_d   = 1'b0;
                confirm_d = 2'd0;
                bundle_o.code[n[1:0]] = EV_RESET;
                n = n + 3'd1;
              end else begin
                confirm_d = confirm_inc;
              end
            end else if (!mfired_d && (held < {16'd0, cfg_i.click_limit_ms})) begin
              // Short press: menu step, or one more click.
              if (menu_active_i) begin
                bundle_o.code[n[1:0]] = EV_NEXT;
                n = n + 3'd1;
              end else begin
                if (pend_d < CLICK_CAP) begin
                  pend_d = pend_d + 2'd1;
                end
                lct_d = tick_d;
              end
            end
          end
          // Every release clears the hold tracking.
          pstart_d = 32'd0;
          pvalid_d = 1'b0;
          mfired_d = 1'b0;
          wfired_d = 1'b0;
          lfired_d = 1'b0;
        end
      end
    end

    bundle_o.count = n;
  end

  // State advances once per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= '0;
      prior_q    <= 1'b0;
      change_q   <= '0;
      stable_q   <= 1'b0;
      pstart_q   <= '0;
      pvalid_q   <= 1'b0;
      mfired_q   <= 1'b0;
      wfired_q   <= 1'b0;
      lfired_q   <= 1'b0;
      armed_q    <= 1'b0;
      deadline_q <= '0;
      confirm_q  <= '0;
      pend_q     <= '0;
      lct_q      <= '0;
    end else if (accept_i) begin
      tick_q     <= tick_d;
      prior_q    <= prior_d;
      change_q   <= change_d;
      stable_q   <= stable_d;
      pstart_q   <= pstart_d;
      pvalid_q   <= pvalid_d;
      mfired_q   <= mfired_d;
      wfired_q   <= wfired_d;
      lfired_q   <= lfired_d;
      armed_q    <= armed_d;
      deadline_q <= deadline_d;
      confirm_q  <= confirm_d;
      pend_q     <= pend_d;
      lct_q      <= lct_d;
    end
  end

endmodule

>>> hdl/bgr_out_buf.sv
// Result register for the recogniser: holds the events of one tick and hands
// them out one item per handshake. Depends on bgr_pkg.
module bgr_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  bgr_pkg::evt_bundle_t bundle_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [3:0]           event_code_o,
  output logic [1:0]           click_total_o,
  output logic                 last_of_run_o
);
  import bgr_pkg::*;

  logic            busy_q, busy_d;
  logic [1:0]      rd_q, rd_d;
  logic [1:0]      last_q;
  logic [3:0][3:0] code_q;
  logic [3:0][1:0] clicks_q;
  logic            pop;
  logic            is_last;

  // Current item and handshake.
  assign is_last       = (rd_q == last_q);
  assign pop           = busy_q && !out_stall_i;
  assign free_o        = !busy_q || (pop && is_last);
  assign out_valid_o   = busy_q;
  assign event_code_o  = code_q[rd_q];
  assign click_total_o = clicks_q[rd_q];
  assign last_of_run_o = is_last;

  // Read pointer and occupancy.
  always_comb begin
    busy_d = busy_q;
    rd_d   = rd_q;
    if (pop) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        rd_d = rd_q + 2'd1;
      end
    end
    if (load_i && (bundle_i.count != 3'd0)) begin
      busy_d = 1'b1;
      rd_d   = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rd_q   <= '0;
    end else begin
      busy_q <= busy_d;
      rd_q   <= rd_d;
    end
  end

  // Payload of the held tick.
  always_ff @(posedge clk_i) begin
    if (load_i && (bundle_i.count != 3'd0)) begin
      code_q   <= bundle_i.code;
      clicks_q <= bundle_i.clicks;
      last_q   <= 2'(bundle_i.count - 3'd1);
    end
  end

endmodule

>>> hdl/button_gesture_recognizer_unit.sv
// Button gesture recogniser, top level: configuration registers, core and
// result register. Depends on bgr_pkg, bgr_core and bgr_out_buf.
//
// Each input item is one millisecond tick carrying the raw pin level and the
// menu flags. The events of an accepted tick (none to four) are loaded into
// the result register, which hands them out one item per cycle while the
// receiver does not stall. A tick that gives at most one event leaves the
// input free in the next cycle when that event is taken at once, so ticks
// can arrive every cycle; a tick that gives more events keeps the input
// stalled while the result register drains, and for every cycle in which
// the receiver stalls. Configuration writes take effect at once and should
// be made while the block is idle.
module button_gesture_recognizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        pin_level_i,
  input  logic        menu_active_i,
  input  logic        menu_enabled_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  event_code_o,
  output logic [1:0]  click_total_o,
  output logic        last_of_run_o
);
  import bgr_pkg::*;

  cfg_t        cfg_q;
  evt_bundle_t bundle;
  logic        free;
  logic        accept;
  logic [10:0] win_raw;
  logic [10:0] win_clamped;

  assign in_stall_o = !free;
  assign accept     = in_valid_i && free;

  // Click window is clamped into its legal range when written.
  assign win_raw = cfg_data_i[10:0];
  always_comb begin
    if (win_raw < CLICK_WIN_MIN) begin
      win_clamped = CLICK_WIN_MIN;
    end else if (win_raw > CLICK_WIN_MAX) begin
      win_clamped = CLICK_WIN_MAX;
    end else begin
      win_clamped = win_raw;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms       <= 16'd50;
      cfg_q.medium_hold_ms    <= 16'd2000;
      cfg_q.warning_hold_ms   <= 16'd7000;
      cfg_q.long_hold_ms      <= 16'd10000;
      cfg_q.confirm_window_ms <= 16'd5000;
      cfg_q.click_limit_ms    <= 16'd1000;
      cfg_q.click_window_ms   <= 11'd400;
      cfg_q.active_low        <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DEBOUNCE:    cfg_q.debounce_ms       <= cfg_data_i;
        CFG_MEDIUM_HOLD: cfg_q.medium_hold_ms    <= cfg_data_i;
        CFG_WARN_HOLD:   cfg_q.warning_hold_ms   <= cfg_data_i;
        CFG_LONG_HOLD:   cfg_q.long_hold_ms      <= cfg_data_i;
        CFG_CONFIRM_WIN: cfg_q.confirm_window_ms <= cfg_data_i;
        CFG_SHORT_MAX:   cfg_q.click_limit_ms    <= cfg_data_i;
        CFG_CLICK_WIN:   cfg_q.click_window_ms   <= win_clamped;
        CFG_ACTIVE_LOW:  cfg_q.active_low        <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Gesture state and event generation.
  bgr_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .pin_level_i    (pin_level_i),
    .menu_active_i  (menu_active_i),
    .menu_enabled_i (menu_enabled_i),
    .cfg_i          (cfg_q),
    .bundle_o       (bundle)
  );

  // Result register and serialiser.
  bgr_out_buf u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept),
    .bundle_i      (bundle),
    .free_o        (free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_code_o  (event_code_o),
    .click_total_o (click_total_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
